[rtl/rcba_pkg.sv]
// shared types and constants for the reference-counted buffer allocator
// no dependencies; imported by every rtl module of the block but rcba_ram

package rcba_pkg;

  localparam int NBR_BUF_DEF    = 64;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths of the item and result beats
  localparam int ID_W      = 6;
  localparam int AMT_W     = 8;
  localparam int CNT_OUT_W = 16;
  localparam int ACNT_W    = 7;
  localparam int RSV_W     = 7;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_ADD     = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_RESERVED  = 3'd1,
    STATUS_NO_ROOM   = 3'd2,
    STATUS_NOT_ALLOC = 3'd3,
    STATUS_EXCEEDS   = 3'd4,
    STATUS_OVERFLOW  = 3'd5
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [ID_W-1:0]    buf_id;
    logic [AMT_W-1:0]   use_amount;
  } rcba_in_t;

  typedef struct packed {
    logic [ID_W-1:0]      result_buf;
    logic [CNT_OUT_W-1:0] use_count_now;
    logic [ACNT_W-1:0]    alloc_count;
    logic                 room_left;
    status_e              status;
  } rcba_out_t;

  // enables from the sequencer to the three state memories
  typedef struct packed {
    logic rd_en;
    logic ord_we;
    logic pos_we;
    logic cnt_we;
  } rcba_mem_ctl_t;

  typedef enum logic [2:0] {
    SEQ_SWEEP,
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_SWAP,
    SEQ_CLR_OUT
  } seq_state_e;

endpackage

[rtl/rcba_ram.sv]
// single-port-write, single-port-read synchronous ram with registered read data
// no dependencies; used for the order list, position table and use counts

module rcba_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rcba_seq.sv]
// sequencer and datapath: read-modify-write over the three state memories
// depends on rcba_pkg; drives the rams instantiated in the top level

module rcba_seq #(
  parameter int NBR_BUF    = rcba_pkg::NBR_BUF_DEF,
  parameter int COUNT_BITS = rcba_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcba_pkg::RSV_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  rcba_pkg::rcba_in_t            in_data_i,
  output logic                          in_ready_o,
  input  logic                          out_free_i,
  output logic                          res_load_o,
  output rcba_pkg::rcba_out_t           res_item_o,
  output rcba_pkg::rcba_mem_ctl_t       mem_ctl_o,
  output logic [$clog2(NBR_BUF)-1:0]    ord_raddr_o,
  output logic [$clog2(NBR_BUF)-1:0]    id_raddr_o,
  output logic [$clog2(NBR_BUF)-1:0]    ord_waddr_o,
  output logic [$clog2(NBR_BUF)-1:0]    ord_wdata_o,
  output logic [$clog2(NBR_BUF)-1:0]    pos_waddr_o,
  output logic [$clog2(NBR_BUF)-1:0]    pos_wdata_o,
  output logic [$clog2(NBR_BUF)-1:0]    cnt_waddr_o,
  output logic [COUNT_BITS-1:0]         cnt_wdata_o,
  input  logic [$clog2(NBR_BUF)-1:0]    ord_rdata_i,
  input  logic [$clog2(NBR_BUF)-1:0]    pos_rdata_i,
  input  logic [COUNT_BITS-1:0]         cnt_rdata_i
);

  import rcba_pkg::*;

  localparam int IW = $clog2(NBR_BUF);
  localparam int BW = $clog2(NBR_BUF + 1);
  localparam int CW = (BW > RSV_W) ? BW : RSV_W;
  localparam int AW = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;
  localparam logic [AW-1:0] CNT_MAX = AW'((64'd1 << COUNT_BITS) - 64'd1);

  function automatic logic [BW-1:0] eff_rsv(input logic [RSV_W-1:0] r);
    logic [CW-1:0] rx;
    rx = CW'(r);
    return (rx > CW'(NBR_BUF)) ? BW'(NBR_BUF) : BW'(rx);
  endfunction

  seq_state_e        state_q, state_d;
  logic [RSV_W-1:0]  rsv_q, rsv_d;
  logic [BW-1:0]     fb_q, fb_d;
  rcba_in_t          item_q, item_d;
  logic [IW-1:0]     sweep_q, sweep_d;
  logic              pend_q, pend_d;

  logic [BW-1:0]     eff;
  logic [BW-1:0]     fb_dec;
  logic [BW-1:0]     fb_new;
  logic [IW-1:0]     id_idx;
  logic [IW-1:0]     last_idx;
  logic              is_rsv;
  logic              id_oor;
  logic              not_alloc;
  logic              full;
  logic [AW-1:0]     cnt_ext;
  logic [AW-1:0]     amt_ext;
  logic [AW-1:0]     sum;
  logic [AW-1:0]     diff;
  logic [ID_W-1:0]   r_buf;
  logic [COUNT_BITS-1:0] r_cnt;
  status_e           r_st;
  logic              do_cnt_we;
  logic [IW-1:0]     r_cnt_waddr;
  logic [COUNT_BITS-1:0] r_cnt_wdata;
  logic              do_swap;

  // operation evaluation on the registered item and the ram read data
  always_comb begin
    eff       = eff_rsv(rsv_q);
    fb_dec    = BW'(fb_q - BW'(1));
    id_idx    = IW'(item_q.buf_id);
    last_idx  = IW'(fb_q);
    is_rsv    = CW'(item_q.buf_id) < CW'(eff);
    id_oor    = CW'(item_q.buf_id) >= CW'(NBR_BUF);
    not_alloc = id_oor || (BW'(pos_rdata_i) >= fb_q);
    full      = fb_q >= BW'(NBR_BUF);
    cnt_ext   = AW'(cnt_rdata_i);
    amt_ext   = AW'(item_q.use_amount);
    sum       = cnt_ext + amt_ext;
    diff      = cnt_ext - amt_ext;

    r_buf       = '0;
    r_cnt       = '0;
    r_st        = STATUS_OK;
    fb_new      = fb_q;
    do_cnt_we   = 1'b0;
    r_cnt_waddr = id_idx;
    r_cnt_wdata = '0;
    do_swap     = 1'b0;

    case (item_q.func)
      FUNC_ALLOC: begin
        if (full) begin
          r_st = STATUS_NO_ROOM;
        end else if (amt_ext > CNT_MAX) begin
          r_st = STATUS_OVERFLOW;
        end else begin
          r_buf       = ID_W'(ord_rdata_i);
          r_cnt       = COUNT_BITS'(amt_ext);
          do_cnt_we   = 1'b1;
          r_cnt_waddr = ord_rdata_i;
          r_cnt_wdata = COUNT_BITS'(amt_ext);
          fb_new      = BW'(fb_q + BW'(1));
        end
      end
      FUNC_ADD, FUNC_RELEASE: begin
        r_buf = item_q.buf_id;
        if (is_rsv) begin
          r_st = STATUS_RESERVED;
        end else if (not_alloc) begin
          r_st  = STATUS_NOT_ALLOC;
          r_cnt = id_oor ? '0 : cnt_rdata_i;
        end else if (item_q.func == FUNC_ADD) begin
          r_cnt = cnt_rdata_i;
          if (sum > CNT_MAX) begin
            r_st = STATUS_OVERFLOW;
          end else begin
            r_cnt       = COUNT_BITS'(sum);
            do_cnt_we   = 1'b1;
            r_cnt_wdata = COUNT_BITS'(sum);
          end
        end else begin
          r_cnt = cnt_rdata_i;
          if (amt_ext > cnt_ext) begin
            r_st = STATUS_EXCEEDS;
          end else begin
            r_cnt       = COUNT_BITS'(diff);
            do_cnt_we   = 1'b1;
            r_cnt_wdata = COUNT_BITS'(diff);
            if ((diff == '0) && (fb_q > eff)) begin
              do_swap = 1'b1;
              fb_new  = fb_dec;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_item_o.result_buf    = r_buf;
    res_item_o.use_count_now = CNT_OUT_W'(r_cnt);
    res_item_o.alloc_count   = ACNT_W'(CW'(fb_new) - CW'(eff));
    res_item_o.room_left     = fb_new < BW'(NBR_BUF);
    res_item_o.status        = r_st;
  end

  // next state, ram control
  always_comb begin
    state_d    = state_q;
    rsv_d      = rsv_q;
    fb_d       = fb_q;
    item_d     = item_q;
    sweep_d    = sweep_q;
    pend_d     = pend_q;
    mem_ctl_o  = '0;
    res_load_o = 1'b0;
    in_ready_o = (state_q == SEQ_IDLE);

    ord_raddr_o = (in_data_i.func == FUNC_ALLOC) ? IW'(fb_q) : IW'(fb_dec);
    id_raddr_o  = IW'(in_data_i.buf_id);
    ord_waddr_o = sweep_q;
    ord_wdata_o = sweep_q;
    pos_waddr_o = sweep_q;
    pos_wdata_o = sweep_q;
    cnt_waddr_o = sweep_q;
    cnt_wdata_o = '0;

    case (state_q)
      SEQ_SWEEP: begin
        mem_ctl_o.ord_we = 1'b1;
        mem_ctl_o.pos_we = 1'b1;
        mem_ctl_o.cnt_we = 1'b1;
        if (sweep_q == IW'(NBR_BUF - 1)) begin
          sweep_d = '0;
          state_d = pend_q ? SEQ_CLR_OUT : SEQ_IDLE;
        end else begin
          sweep_d = IW'(sweep_q + IW'(1));
        end
      end
      SEQ_IDLE: begin
        if (in_valid_i) begin
          mem_ctl_o.rd_en = 1'b1;
          item_d          = in_data_i;
          state_d         = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (item_q.func == FUNC_CLEAR) begin
          fb_d    = eff;
          pend_d  = 1'b1;
          sweep_d = '0;
          state_d = SEQ_SWEEP;
        end else if (out_free_i) begin
          res_load_o       = 1'b1;
          mem_ctl_o.cnt_we = do_cnt_we;
          cnt_waddr_o      = r_cnt_waddr;
          cnt_wdata_o      = r_cnt_wdata;
          // first half of the swap: the boundary id takes the freed slot
          mem_ctl_o.pos_we = do_swap;
          pos_waddr_o      = ord_rdata_i;
          pos_wdata_o      = pos_rdata_i;
          mem_ctl_o.ord_we = do_swap;
          ord_waddr_o      = pos_rdata_i;
          ord_wdata_o      = ord_rdata_i;
          fb_d             = fb_new;
          state_d          = do_swap ? SEQ_SWAP : SEQ_IDLE;
        end
      end
      SEQ_SWAP: begin
        // second half: freed id lands on the new boundary
        mem_ctl_o.pos_we = 1'b1;
        pos_waddr_o      = id_idx;
        pos_wdata_o      = last_idx;
        mem_ctl_o.ord_we = 1'b1;
        ord_waddr_o      = last_idx;
        ord_wdata_o      = id_idx;
        state_d          = SEQ_IDLE;
      end
      SEQ_CLR_OUT: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          pend_d     = 1'b0;
          state_d    = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      rsv_d   = cfg_wdata_i;
      fb_d    = eff_rsv(cfg_wdata_i);
      sweep_d = '0;
      pend_d  = 1'b0;
      state_d = SEQ_SWEEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_SWEEP;
      rsv_q   <= '0;
      fb_q    <= '0;
      sweep_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rsv_q   <= rsv_d;
      fb_q    <= fb_d;
      sweep_q <= sweep_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

[rtl/refcounted_buffer_allocator_core.sv]
// top level of the reference-counted buffer allocator
// depends on rcba_pkg, rcba_ram and rcba_seq
//
//   channel  | signals                              | beat taken when
//   ---------+--------------------------------------+------------------------
//   in       | in_valid_i, in_ready_o, in_data_i    | in_valid_i & in_ready_o
//   out      | out_valid_o, out_ready_i, out_data_o | out_valid_o & out_ready_i
//   cfg      | cfg_we_i, cfg_wdata_i                | cfg_we_i
//
// allocate, add and release accept with ram read, then execute and write back;
// a release that frees an id adds a swap step, as the swap writes both rams twice
// clear steps through accept, execute, a one-entry-a-cycle sweep to identity order and
// zero counts, then the result beat
// reset and every cfg write start the same sweep with in_ready_o low
// a full output register stalls execution, and the next item waits until it drains

module refcounted_buffer_allocator_core #(
  parameter int NBR_BUF    = rcba_pkg::NBR_BUF_DEF,
  parameter int COUNT_BITS = rcba_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rcba_pkg::RSV_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rcba_pkg::rcba_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rcba_pkg::rcba_out_t        out_data_o
);

  import rcba_pkg::*;

  localparam int IW = $clog2(NBR_BUF);

  rcba_mem_ctl_t          mem_ctl;
  logic                   res_load;
  rcba_out_t              res_item;
  logic                   out_free;

  // ram address and data buses
  logic [IW-1:0]          ord_raddr;
  logic [IW-1:0]          id_raddr;
  logic [IW-1:0]          ord_waddr;
  logic [IW-1:0]          ord_wdata;
  logic [IW-1:0]          pos_waddr;
  logic [IW-1:0]          pos_wdata;
  logic [IW-1:0]          cnt_waddr;
  logic [COUNT_BITS-1:0]  cnt_wdata;
  logic [IW-1:0]          ord_rdata;
  logic [IW-1:0]          pos_rdata;
  logic [COUNT_BITS-1:0]  cnt_rdata;

  // output register
  logic                   out_valid_q, out_valid_d;
  rcba_out_t              out_data_q;

  // result may be loaded when the slot is empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  rcba_seq #(
    .NBR_BUF    (NBR_BUF),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_item_o  (res_item),
    .mem_ctl_o   (mem_ctl),
    .ord_raddr_o (ord_raddr),
    .id_raddr_o  (id_raddr),
    .ord_waddr_o (ord_waddr),
    .ord_wdata_o (ord_wdata),
    .pos_waddr_o (pos_waddr),
    .pos_wdata_o (pos_wdata),
    .cnt_waddr_o (cnt_waddr),
    .cnt_wdata_o (cnt_wdata),
    .ord_rdata_i (ord_rdata),
    .pos_rdata_i (pos_rdata),
    .cnt_rdata_i (cnt_rdata)
  );

  // order list: position -> id
  rcba_ram #(
    .DEPTH (NBR_BUF),
    .WIDTH (IW)
  ) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (mem_ctl.rd_en),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // inverse table: id -> position
  rcba_ram #(
    .DEPTH (NBR_BUF),
    .WIDTH (IW)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (mem_ctl.rd_en),
    .raddr_i (id_raddr),
    .rdata_o (pos_rdata)
  );

  // use counts per id
  rcba_ram #(
    .DEPTH (NBR_BUF),
    .WIDTH (COUNT_BITS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (mem_ctl.rd_en),
    .raddr_i (id_raddr),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/rcba_checker.sv]
// port-level checker for the reference-counted buffer allocator
// depends on rcba_pkg; bound to refcounted_buffer_allocator_core below

module rcba_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rcba_pkg::rcba_out_t out_data_o
);

  import rcba_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one executes");

  // a cfg write starts the clearing sweep
  a_cfg_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input ready right after cfg write");

  // no room must agree with room_left
  a_no_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_NO_ROOM) |-> !out_data_o.room_left)
    else $error("no room reported with room left");

  // a reserved id reports a zero count
  a_reserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_RESERVED)
      |-> (out_data_o.use_count_now == '0))
    else $error("reserved id reported a nonzero count");

endmodule

bind refcounted_buffer_allocator_core rcba_props u_rcba_props (.*);

[sim/rcba_checker.sv]
// scoreboard for the reference-counted buffer allocator: predicts every result beat
// depends on rcba_pkg; watches the cfg, in and out channels of the core
`timescale 1ns / 1ps

module rcba_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rcba_pkg::RSV_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  rcba_pkg::rcba_in_t         in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  rcba_pkg::rcba_out_t        out_data_i,
  output int                         pending_o,
  output int                         mismatch_o
);

  import rcba_pkg::*;

  localparam int NBR_BUF    = NBR_BUF_DEF;
  localparam int COUNT_MAX  = (1 << COUNT_BITS_DEF) - 1;

  // mirror of the allocator state
  logic [ID_W-1:0] id_at_pos [NBR_BUF];
  logic [ID_W-1:0] pos_of_id [NBR_BUF];
  int unsigned     uses      [NBR_BUF];
  int              boundary;
  int              reserved_cfg;

  rcba_out_t       expected_results [$];

  function automatic int eff_reserved();
    return (reserved_cfg > NBR_BUF) ? NBR_BUF : reserved_cfg;
  endfunction

  function automatic void wipe_state();
    for (int i = 0; i < NBR_BUF; i++) begin
      id_at_pos[i] = ID_W'(i);
      pos_of_id[i] = ID_W'(i);
      uses[i]      = 0;
    end
    boundary = eff_reserved();
  endfunction

  function automatic rcba_out_t predict_outcome(rcba_in_t req);
    rcba_out_t   r;
    int          eff;
    int          id;
    int          amt;
    int          slot;
    int          last;
    int unsigned cnt;
    logic [ID_W-1:0] other;
    eff = eff_reserved();
    id  = int'(req.buf_id);
    amt = int'(req.use_amount);
    r   = '0;
    r.status = STATUS_OK;
    cnt = 0;
    case (req.func)
      FUNC_ALLOC: begin
        // an 8-bit amount always fits a fresh count
        if (boundary >= NBR_BUF) begin
          r.status = STATUS_NO_ROOM;
        end else begin
          r.result_buf = id_at_pos[boundary];
          uses[id_at_pos[boundary]] = amt;
          cnt = amt;
          boundary++;
        end
      end
      FUNC_CLEAR: begin
        wipe_state();
      end
      default: begin
        r.result_buf = req.buf_id;
        if (id < eff) begin
          r.status = STATUS_RESERVED;
        end else if (int'(pos_of_id[id]) >= boundary) begin
          r.status = STATUS_NOT_ALLOC;
          cnt = uses[id];
        end else if (req.func == FUNC_ADD) begin
          cnt = uses[id];
          if (cnt + amt > COUNT_MAX) begin
            r.status = STATUS_OVERFLOW;
          end else begin
            cnt += amt;
            uses[id] = cnt;
          end
        end else begin
          cnt = uses[id];
          if (amt > cnt) begin
            r.status = STATUS_EXCEEDS;
          end else begin
            cnt -= amt;
            uses[id] = cnt;
            // freed id swaps with the last allocated slot
            if (cnt == 0 && boundary > eff) begin
              slot = int'(pos_of_id[id]);
              boundary--;
              last  = boundary;
              other = id_at_pos[last];
              pos_of_id[other] = ID_W'(slot);
              pos_of_id[id]    = ID_W'(last);
              id_at_pos[slot]  = other;
              id_at_pos[last]  = ID_W'(id);
            end
          end
        end
      end
    endcase
    r.use_count_now = cnt[CNT_OUT_W-1:0];
    r.alloc_count   = ACNT_W'(boundary - eff);
    r.room_left     = (boundary < NBR_BUF);
    return r;
  endfunction

  function automatic void report(string field, int exp_v, int got_v);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, got_v);
    mismatch_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rcba_out_t exp_r;
    if (!rst_ni) begin
      reserved_cfg = 0;
      wipe_state();
      expected_results.delete();
      pending_o  = 0;
      mismatch_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none actual %h",
                   $time, out_data_i);
          mismatch_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_i.result_buf !== exp_r.result_buf)
            report("result_buf", exp_r.result_buf, out_data_i.result_buf);
          if (out_data_i.use_count_now !== exp_r.use_count_now)
            report("use_count_now", exp_r.use_count_now, out_data_i.use_count_now);
          if (out_data_i.alloc_count !== exp_r.alloc_count)
            report("alloc_count", exp_r.alloc_count, out_data_i.alloc_count);
          if (out_data_i.room_left !== exp_r.room_left)
            report("room_left", exp_r.room_left, out_data_i.room_left);
          if (out_data_i.status !== exp_r.status)
            report("status", exp_r.status, out_data_i.status);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(predict_outcome(in_data_i));
      if (cfg_we_i) begin
        reserved_cfg = int'(cfg_wdata_i);
        wipe_state();
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[sim/tb_refcounted_buffer_allocator_core.sv]
// top of the allocator testbench: clock, reset, stimulus, back-pressure and verdict
// depends on rcba_pkg, the core and rcba_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_refcounted_buffer_allocator_core;
  import rcba_pkg::*;

  localparam int IDLE_LIMIT   = 3000;   // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 1700;
  localparam int PUMP_ADDS    = 258;    // enough 255-adds to hit the count ceiling

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [RSV_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  rcba_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  rcba_out_t        out_data_o;

  int pending_beats;
  int mismatch_total;
  int items_sent;
  int cur_reserved;    // effective reserved count, steers the id picks
  int win_span;        // width of the hot id window above the reserved ids
  bit src_steady;      // sender runs back to back
  bit sink_steady = 1'b0;  // receiver starts no new stalls
  int stall_left  = 0;
  int idle_cycles = 0;

  refcounted_buffer_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  rcba_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .pending_o   (pending_beats),
    .mismatch_o  (mismatch_total)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // stall lengths: mostly short, now and then a long one
  function automatic int pause_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side: random stalls, with stretches of steady ready
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      stall_left = pause_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("refcounted_buffer_allocator_core verification failed");
        $finish;
      end
    end
  end

  // one request beat, with an optional gap in front of it
  task automatic send_beat(func_e f, int id, int amt);
    rcba_in_t item;
    item.func       = f;
    item.buf_id     = ID_W'(id);
    item.use_amount = AMT_W'(amt);
    if (!src_steady && $urandom_range(0, 1) == 0) begin
      // valid drops only at a step where it is not raised again
      in_valid_i <= 1'b0;
      repeat (pause_len()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // hold off until every predicted result beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_beats != 0);
    @(posedge clk_i);
  endtask

  // register write only on an idle core; it also clears the allocator
  task automatic write_reserved(int v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= RSV_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_reserved = (v > NBR_BUF_DEF) ? NBR_BUF_DEF : v;
  endtask

  // mostly ids in the busy window just above the reserved ones
  function automatic int pick_id();
    if (cur_reserved < NBR_BUF_DEF && $urandom_range(0, 3) != 0)
      return cur_reserved + $urandom_range(0, win_span - 1);
    return $urandom_range(0, NBR_BUF_DEF - 1);
  endfunction

  // small amounts so releases reach zero often
  function automatic int pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 82) return 0;
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int    sel;
    int    v;
    int    n;
    int    r;
    func_e f;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    items_sent   = 0;
    cur_reserved = 0;
    win_span     = 8;
    src_steady   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two reserved ids, every op and the ok, reserved, not-allocated and exceeds statuses
    write_reserved(2);
    send_beat(FUNC_ALLOC, 0, 255);
    send_beat(FUNC_ALLOC, 0, 0);          // zero count allocation
    send_beat(FUNC_ADD, 2, 1);
    send_beat(FUNC_ADD, 0, 5);            // reserved id ignored
    send_beat(FUNC_RELEASE, 1, 3);        // reserved id ignored
    send_beat(FUNC_ADD, 63, 1);           // never allocated
    send_beat(FUNC_RELEASE, 40, 1);       // never allocated
    send_beat(FUNC_RELEASE, 2, 255);
    send_beat(FUNC_RELEASE, 2, 2);        // more than the count
    send_beat(FUNC_RELEASE, 2, 1);        // count hits zero, swap to boundary
    send_beat(FUNC_RELEASE, 3, 0);        // zero release frees a zero count
    send_beat(FUNC_ALLOC, 0, 1);
    send_beat(FUNC_ADD, 2, 0);
    send_beat(FUNC_CLEAR, 63, 255);
    send_beat(FUNC_ALLOC, 63, 128);
    // one free id only: second allocation finds no room
    write_reserved(63);
    send_beat(FUNC_ALLOC, 0, 7);
    send_beat(FUNC_ALLOC, 0, 1);
    send_beat(FUNC_ADD, 63, 170);
    send_beat(FUNC_RELEASE, 63, 177);
    send_beat(FUNC_ALLOC, 0, 255);
    // everything reserved, then a register value past the id range
    write_reserved(64);
    send_beat(FUNC_ALLOC, 0, 1);
    send_beat(FUNC_ADD, 0, 9);
    send_beat(FUNC_RELEASE, 63, 1);
    send_beat(FUNC_CLEAR, 0, 0);
    write_reserved(127);
    send_beat(FUNC_ALLOC, 0, 1);
    send_beat(FUNC_ADD, 63, 255);

    // pump one id up to the count ceiling and past it
    write_reserved(0);
    src_steady = 1'b1;
    send_beat(FUNC_ALLOC, 0, 255);
    repeat (PUMP_ADDS / 2) send_beat(FUNC_ADD, 0, 255);
    drain();                              // sender waits for every result mid-stream
    src_steady = 1'b0;
    repeat (PUMP_ADDS - PUMP_ADDS / 2) send_beat(FUNC_ADD, 0, 255);
    repeat (3) send_beat(FUNC_RELEASE, 0, 255);

    // random phases, each under its own reserved count
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       v = 0;
        1:       v = NBR_BUF_DEF;
        2:       v = $urandom_range(NBR_BUF_DEF + 1, 127);
        3:       v = NBR_BUF_DEF - 1;
        default: v = $urandom_range(1, 60);
      endcase
      write_reserved(v);
      if (cur_reserved < NBR_BUF_DEF)
        win_span = $urandom_range(1, (NBR_BUF_DEF - cur_reserved < 16) ?
                                     NBR_BUF_DEF - cur_reserved : 16);
      src_steady = ($urandom_range(0, 3) == 0);
      n = (cur_reserved >= NBR_BUF_DEF) ? 8 : $urandom_range(60, 200);
      repeat (n) begin
        if ($urandom_range(0, 49) == 0) drain();
        r = $urandom_range(0, 99);
        if (r < 32)      f = FUNC_ALLOC;
        else if (r < 58) f = FUNC_ADD;
        else if (r < 96) f = FUNC_RELEASE;
        else             f = FUNC_CLEAR;
        send_beat(f, pick_id(), pick_amount());
        if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
      end
    end

    // wind down and give the verdict
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_total == 0 && pending_beats == 0) begin
      $display("refcounted_buffer_allocator_core verification clean");
    end else begin
      $display("refcounted_buffer_allocator_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rcba_pkg.sv
rtl/rcba_ram.sv
rtl/rcba_seq.sv
rtl/refcounted_buffer_allocator_core.sv
rtl/rcba_checker.sv
sim/rcba_checker.sv
sim/tb_refcounted_buffer_allocator_core.sv
